[design/efs_pkg.sv]
// Shared types, constants and codes for the elevator floor scheduler.
package efs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int FLOOR_COUNT = 10;

	localparam int QA_W       = $clog2(QUEUE_DEPTH);
	localparam int QC_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DOOR_IDX_W = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
	localparam int FLOOR_W    = 4;
	localparam int COUNT_W    = 5;
	localparam int TRAVEL_W   = 13;
	localparam int DOOR_W     = 16;
	localparam int WAIT_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [FLOOR_W-1:0]  MAX_FLOOR_TOP = FLOOR_W'(FLOOR_COUNT - 1);
	localparam logic [TRAVEL_W-1:0] TRAVEL_RESET  = TRAVEL_W'(1000);
	localparam logic [TRAVEL_W-1:0] TRAVEL_MIN    = TRAVEL_W'(500);
	localparam logic [TRAVEL_W-1:0] TRAVEL_MAX    = TRAVEL_W'(5000);
	localparam logic [DOOR_W-1:0]   DOOR_RESET    = DOOR_W'(4000);
	localparam logic [WAIT_W-1:0]   ELAPSED_MAX   = {WAIT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOOR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		OP_TICK,
		OP_REQUEST,
		OP_DOOR,
		OP_CAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [FLOOR_W-1:0] floor;
		logic [DOOR_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] current_floor;
		logic               waiting;
		logic               arrived;
		logic               at_target;
		logic [COUNT_W-1:0] queue_count;
		logic               accepted;
		logic               overflow;
	} rsp_t;

	typedef struct packed {
		logic               stop;
		logic [FLOOR_W-1:0] floor;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TICK,
		S_TICK_POP,
		S_REQ,
		S_REQ_LOAD,
		S_REQ_CHECK,
		S_PRE_RD,
		S_PRE_CK,
		S_WALK,
		S_TGT_RD,
		S_TGT_CK,
		S_SET,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_HEAD,
		RD_TAIL,
		RD_SRCH
	} rd_sel_t;

	typedef struct packed {
		logic    accept;
		rd_sel_t rd_sel;
		logic    load_start;
		logic    set_accepted;
		logic    walk_init;
		logic    srch_init;
		logic    srch_next;
		logic    mark;
		logic    walk_step;
		logic    push_target;
		logic    tick_apply;
		logic    wait_step;
		logic    apply_set;
		logic    emit;
	} efs_cmd_t;

	typedef struct packed {
		op_t  op;
		logic can_pop;
		logic tail_start;
		logic req_ok;
		logic test_mode;
		logic srch_end;
		logic srch_hit;
		logic walk_last;
		logic out_busy;
	} efs_stat_t;

endpackage

[design/efs_ctrl.sv]
// Controller state machine that sequences ticks, requests and setting writes.
module efs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  efs_pkg::efs_stat_t  stat,
	output efs_pkg::efs_cmd_t   cmd
);
	import efs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (stat.op) inside
						OP_TICK:        state_d = S_TICK;
						OP_REQUEST:     state_d = S_REQ;
						OP_DOOR, OP_CAR: state_d = S_SET;
					endcase
				end
			end
			S_TICK:      state_d = stat.can_pop ? S_TICK_POP : S_DONE;
			S_TICK_POP:  state_d = S_DONE;
			S_REQ:       state_d = stat.tail_start ? S_REQ_LOAD : S_REQ_CHECK;
			S_REQ_LOAD:  state_d = S_REQ_CHECK;
			S_REQ_CHECK: begin
				if (!stat.req_ok) begin
					state_d = S_DONE;
				end else begin
					state_d = stat.test_mode ? S_PRE_RD : S_WALK;
				end
			end
			S_PRE_RD:    state_d = stat.srch_end ? S_WALK : S_PRE_CK;
			S_PRE_CK:    state_d = stat.srch_hit ? S_DONE : S_PRE_RD;
			S_WALK:      state_d = stat.walk_last ? S_TGT_RD : S_WALK;
			S_TGT_RD:    state_d = stat.srch_end ? S_DONE : S_TGT_CK;
			S_TGT_CK:    state_d = stat.srch_hit ? S_DONE : S_TGT_RD;
			S_SET:       state_d = S_DONE;
			S_DONE:      state_d = stat.out_busy ? S_DONE : S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_HEAD;
		cmd.accept = accept;
		unique case (state_q)
			S_IDLE: begin
			end
			S_TICK: begin
				cmd.rd_sel    = RD_HEAD;
				cmd.wait_step = !stat.can_pop;
			end
			S_TICK_POP: begin
				cmd.tick_apply = 1'b1;
			end
			S_REQ: begin
				cmd.rd_sel = RD_TAIL;
			end
			S_REQ_LOAD: begin
				cmd.load_start = 1'b1;
			end
			S_REQ_CHECK: begin
				cmd.set_accepted = stat.req_ok;
				cmd.walk_init    = 1'b1;
				cmd.srch_init    = 1'b1;
			end
			S_PRE_RD, S_TGT_RD: begin
				cmd.rd_sel      = RD_SRCH;
				cmd.push_target = (state_q == S_TGT_RD) && stat.srch_end;
			end
			S_PRE_CK, S_TGT_CK: begin
				cmd.mark      = stat.srch_hit;
				cmd.srch_next = !stat.srch_hit;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				cmd.srch_init = stat.walk_last;
			end
			S_SET: begin
				cmd.apply_set = 1'b1;
			end
			S_DONE: begin
				cmd.emit = !stat.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

[design/efs_dp.sv]
// Datapath: settings, floor queue memory, car state, wait counter and result register.
module efs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  efs_pkg::req_t                       req,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [efs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [efs_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output efs_pkg::rsp_t                       rsp,
	input  efs_pkg::efs_cmd_t                   cmd,
	output efs_pkg::efs_stat_t                  stat
);
	import efs_pkg::*;

	// Settings and control state.
	logic [FLOOR_W-1:0]  max_floor_q;
	logic [TRAVEL_W-1:0] travel_q;
	logic                test_q;
	logic [QA_W-1:0]     head_q;
	logic [QC_W-1:0]     size_q;
	logic [FLOOR_W-1:0]  car_q;
	logic                waiting_q;
	logic [WAIT_W-1:0]   limit_q;
	logic [WAIT_W-1:0]   elapsed_q;
	logic [DOOR_W-1:0]   door_q [FLOOR_COUNT];
	logic                rsp_valid_q;

	// Per-item working registers.
	req_t                item_q;
	logic [FLOOR_W-1:0]  start_q;
	logic [FLOOR_W-1:0]  walk_q;
	logic [QC_W-1:0]     k_q;
	logic                arrived_q;
	logic                at_target_q;
	logic                accepted_q;
	logic                overflow_q;
	rsp_t                rsp_q;

	entry_t              mem_q [QUEUE_DEPTH];
	entry_t              rd_q;

	logic [QA_W-1:0]     tail_slot;
	logic [QA_W-1:0]     srch_slot;
	logic [QA_W-1:0]     push_slot;
	logic [QA_W-1:0]     rd_addr;
	logic [QA_W-1:0]     wr_addr;
	entry_t              wr_data;
	entry_t              push_entry;
	logic                wr_en;
	logic                queue_full;
	logic                do_push;
	logic                dir_down;
	logic [FLOOR_W-1:0]  walk_next;
	logic                walk_last;
	logic                pop_ok;
	logic [DOOR_W-1:0]   pop_door;
	logic [WAIT_W-1:0]   new_limit;
	logic [WAIT_W-1:0]   elapsed_inc;
	logic                wait_done;
	logic                door_ok;
	logic                car_ok;
	logic                out_busy;

	// Circular slot arithmetic: one subtract of the depth wraps a sum below twice the depth.
	function automatic logic [QA_W-1:0] slot_add(
		input logic [QA_W-1:0] base,
		input logic [QC_W-1:0] off
	);
		logic [QC_W:0] sum;
		sum = (QC_W+1)'(base) + (QC_W+1)'(off);
		if (sum >= (QC_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (QC_W+1)'(QUEUE_DEPTH);
		end
		return sum[QA_W-1:0];
	endfunction

	function automatic logic [DOOR_W-1:0] door_of(
		input logic [DOOR_W-1:0]  doors [FLOOR_COUNT],
		input logic [FLOOR_W-1:0] f
	);
		logic [DOOR_W-1:0] d;
		d = '0;
		if ((FLOOR_W+1)'(f) < (FLOOR_W+1)'(FLOOR_COUNT)) begin
			d = doors[f[DOOR_IDX_W-1:0]];
		end
		return d;
	endfunction

	assign cfg_ready  = 1'b1;
	assign out_busy   = rsp_valid_q && rsp_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign tail_slot  = slot_add(head_q, size_q - QC_W'(1));
	assign srch_slot  = slot_add(head_q, k_q);
	assign push_slot  = slot_add(head_q, size_q);
	assign queue_full = (size_q == QC_W'(QUEUE_DEPTH));

	assign dir_down   = (start_q > item_q.floor);
	assign walk_next  = dir_down ? (walk_q - FLOOR_W'(1)) : (walk_q + FLOOR_W'(1));
	assign walk_last  = (walk_next == item_q.floor);

	// Floors passed on the way are plain entries; the target entry is a stop.
	assign do_push    = (cmd.walk_step && !walk_last) || cmd.push_target;
	assign push_entry = cmd.push_target ? entry_t'{stop: 1'b1, floor: item_q.floor}
	                                    : entry_t'{stop: 1'b0, floor: walk_next};
	assign wr_en      = (do_push && !queue_full) || cmd.mark;
	assign wr_addr    = cmd.mark ? srch_slot : push_slot;
	assign wr_data    = cmd.mark ? entry_t'{stop: 1'b1, floor: rd_q.floor} : push_entry;

	always_comb begin
		case (cmd.rd_sel)
			RD_HEAD: rd_addr = head_q;
			RD_TAIL: rd_addr = tail_slot;
			RD_SRCH: rd_addr = srch_slot;
			default: rd_addr = head_q;
		endcase
	end

	assign pop_ok      = (rd_q.floor < max_floor_q) && (rd_q.floor != car_q);
	assign pop_door    = rd_q.stop ? door_of(door_q, rd_q.floor) : '0;
	assign new_limit   = WAIT_W'(travel_q) + WAIT_W'(pop_door);
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : (elapsed_q + WAIT_W'(1));
	assign wait_done   = (elapsed_inc >= limit_q);

	assign door_ok = ((FLOOR_W+1)'(item_q.floor) < (FLOOR_W+1)'(FLOOR_COUNT));
	assign car_ok  = (item_q.floor < max_floor_q);

	assign stat.op         = req.op;
	assign stat.can_pop    = (size_q != '0) && !waiting_q;
	assign stat.tail_start = test_q && (size_q != '0);
	assign stat.req_ok     = (item_q.floor < max_floor_q) && (item_q.floor != start_q);
	assign stat.test_mode  = test_q;
	assign stat.srch_end   = (k_q == size_q);
	assign stat.srch_hit   = (rd_q.floor == item_q.floor);
	assign stat.walk_last  = walk_last;
	assign stat.out_busy   = out_busy;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_floor_q <= MAX_FLOOR_TOP;
			travel_q    <= TRAVEL_RESET;
			test_q      <= 1'b0;
			head_q      <= '0;
			size_q      <= '0;
			car_q       <= '0;
			waiting_q   <= 1'b0;
			limit_q     <= '0;
			elapsed_q   <= '0;
			for (int i = 0; i < FLOOR_COUNT; i++) begin
				door_q[i] <= DOOR_RESET;
			end
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MAX_FLOOR: begin
						if (cfg_data[FLOOR_W-1:0] <= MAX_FLOOR_TOP) begin
							max_floor_q <= cfg_data[FLOOR_W-1:0];
							if (car_q >= cfg_data[FLOOR_W-1:0]) begin
								car_q <= '0;
							end
						end
					end
					CFG_TRAVEL: begin
						if (cfg_data >= TRAVEL_MIN && cfg_data <= TRAVEL_MAX) begin
							travel_q <= cfg_data;
						end
					end
					CFG_TEST_MODE: begin
						test_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end

			if (do_push && !queue_full) begin
				size_q <= size_q + QC_W'(1);
			end

			if (cmd.tick_apply) begin
				head_q <= slot_add(head_q, QC_W'(1));
				size_q <= size_q - QC_W'(1);
				if (pop_ok) begin
					car_q     <= rd_q.floor;
					waiting_q <= 1'b1;
					limit_q   <= new_limit;
					elapsed_q <= '0;
				end
			end

			if (cmd.wait_step && waiting_q) begin
				if (wait_done) begin
					waiting_q <= 1'b0;
					limit_q   <= '0;
					elapsed_q <= '0;
				end else begin
					elapsed_q <= elapsed_inc;
				end
			end

			if (cmd.apply_set) begin
				if (item_q.op == OP_DOOR) begin
					if (door_ok) begin
						door_q[item_q.floor[DOOR_IDX_W-1:0]] <= item_q.value;
					end
				end else if (car_ok) begin
					car_q <= item_q.floor;
				end
			end

			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q      <= req;
			start_q     <= car_q;
			arrived_q   <= 1'b0;
			at_target_q <= 1'b0;
			accepted_q  <= 1'b0;
			overflow_q  <= 1'b0;
		end
		if (cmd.load_start) begin
			start_q <= rd_q.floor;
		end
		if (cmd.set_accepted) begin
			accepted_q <= 1'b1;
		end
		if (cmd.walk_init) begin
			walk_q <= start_q;
		end
		if (cmd.walk_step) begin
			walk_q <= walk_next;
		end
		if (cmd.srch_init) begin
			k_q <= '0;
		end else if (cmd.srch_next) begin
			k_q <= k_q + QC_W'(1);
		end
		if (do_push && queue_full) begin
			overflow_q <= 1'b1;
		end
		if (cmd.tick_apply && pop_ok) begin
			arrived_q   <= 1'b1;
			at_target_q <= rd_q.stop;
		end
		if (cmd.apply_set) begin
			accepted_q <= (item_q.op == OP_DOOR) ? door_ok : car_ok;
		end
		if (cmd.emit) begin
			rsp_q.current_floor <= car_q;
			rsp_q.waiting       <= waiting_q;
			rsp_q.arrived       <= arrived_q;
			rsp_q.at_target     <= at_target_q;
			rsp_q.queue_count   <= COUNT_W'(size_q);
			rsp_q.accepted      <= accepted_q;
			rsp_q.overflow      <= overflow_q;
		end
	end

`ifndef SYNTHESIS
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= QC_W'(QUEUE_DEPTH))
		else $error("queue size exceeds queue depth");

	a_idle_wait_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!waiting_q |-> (limit_q == '0 && elapsed_q == '0))
		else $error("wait counters not cleared while the car is not waiting");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_busy)
		else $error("result word written while the previous one is still held");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_apply |=> (size_q + QC_W'(1)) == $past(size_q))
		else $error("queue pop did not reduce the size by one");
`endif

endmodule

[design/elevator_floor_scheduler.sv]
// A tick reads the queue head, pops it if allowed, then emits its result word; a setting write
// is applied, then emitted. A request checks the floor, walks one step per floor and searches the queue.
// A new word is accepted the cycle after the previous result is registered (one at a time).
// The queue memory has one read port, so each queue search step costs a read and a compare.
// Reset (arst_n low) empties the queue, parks the car at floor 0 and loads the default settings.
module elevator_floor_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  efs_pkg::req_t                       req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output efs_pkg::rsp_t                       rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [efs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [efs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import efs_pkg::*;

	efs_cmd_t  cmd;
	efs_stat_t stat;

	efs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	efs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
